// File: rtl/trilinear_frame_sampler_top_macros.svh
// Assertion macros shared by the sampler RTL.
// Each expects signals clk and rst in the scope that uses it.
`ifndef TRILINEAR_FRAME_SAMPLER_TOP_MACROS_SVH
`define TRILINEAR_FRAME_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tfs_pkg.sv
// Shared constants, codes and structs of the trilinear frame sampler.
// No dependencies; every RTL module file refers to it by scoped names.
`default_nettype none

package tfs_pkg;

  localparam int FRAME_COUNT = 4;
  localparam int MAX_COLS    = 128;
  localparam int MAX_ROWS    = 128;
  localparam int FRAC_BITS   = 8;

  // fixed field widths of the ports
  localparam int SLOT_W     = 2;
  localparam int WROW_W     = 7;
  localparam int WCOL_W     = 7;
  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 10;
  localparam int POS_W      = 15;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ADDR_W  = FRAME_W + ROW_W + COL_W;

  localparam int DIM_MAX  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIM_LOGW = $clog2(DIM_MAX + 1);
  localparam int DIM_W    = (DIM_LOGW > CFG_DATA_W) ? DIM_LOGW : CFG_DATA_W;

  // weights: one axis weight reaches 1 << FRAC_BITS
  localparam int WGT_W  = FRAC_BITS + 1;
  localparam int WTY_W  = 2 * FRAC_BITS + 1;
  localparam int WGT3_W = 3 * FRAC_BITS + 1;
  localparam int PROD_W = SAMPLE_W + WGT3_W + 1;
  localparam int ACC_W  = PROD_W;

  localparam int STEP_W = 3;
  localparam int QDEPTH = 2;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = CFG_DATA_W'(128);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic                       en;
    logic                       we;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             flag;
    logic [WGT_W-1:0] wt;
    logic [WGT_W-1:0] wy;
    logic [WGT_W-1:0] wx;
  } tap_t;

  typedef struct packed {
    logic                       valid;
    logic                       flag;
    logic signed [SAMPLE_W-1:0] sample;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/tfs_store.sv
// Single-port frame store, one access a cycle, read data registered.
// Depends on tfs_pkg for widths and the request struct.
`default_nettype none

module tfs_store (
  input  wire logic                               clk,
  input  wire tfs_pkg::mem_req_t                  req,
  output logic signed [tfs_pkg::SAMPLE_W-1:0]     rdata
);

  localparam int STORE_DEPTH = 1 << tfs_pkg::ADDR_W;

  logic signed [tfs_pkg::SAMPLE_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/tfs_seq.sv
// Input acceptance, coordinate decode and store access sequencing.
// Depends on tfs_pkg; drives the frame store and the tap stream to tfs_mac.
`default_nettype none

module tfs_seq (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              kind,
  input  wire logic [tfs_pkg::SLOT_W-1:0]        frame_slot,
  input  wire logic [tfs_pkg::WROW_W-1:0]        write_row,
  input  wire logic [tfs_pkg::WCOL_W-1:0]        write_col,
  input  wire logic signed [tfs_pkg::SAMPLE_W-1:0] write_value,
  input  wire logic [tfs_pkg::TIME_W-1:0]        query_time,
  input  wire logic [tfs_pkg::POS_W-1:0]         query_row,
  input  wire logic [tfs_pkg::POS_W-1:0]         query_col,
  input  wire logic [tfs_pkg::CFG_DATA_W-1:0]    active_width,
  input  wire logic [tfs_pkg::CFG_DATA_W-1:0]    active_height,
  input  wire logic                              pop,
  output tfs_pkg::mem_req_t                      mem,
  output tfs_pkg::tap_t                          tap
);

  localparam int DW = tfs_pkg::DIM_W;
  localparam int FB = tfs_pkg::FRAC_BITS;
  localparam logic [tfs_pkg::STEP_W-1:0] LAST_STEP = '1;
  localparam logic [tfs_pkg::TIME_W-1:0] T_MAX =
    tfs_pkg::TIME_W'((tfs_pkg::FRAME_COUNT - 1) << FB);
  localparam logic [tfs_pkg::WGT_W-1:0] ONE = tfs_pkg::WGT_W'(1 << FB);

  typedef struct packed {
    logic [DW-1:0] lo;
    logic [DW-1:0] hi;
    logic [FB-1:0] frac;
    logic          sat;
  } split_t;

  function automatic logic [DW-1:0] eff_size(input logic [tfs_pkg::CFG_DATA_W-1:0] r,
                                             input int unsigned mx);
    logic [DW-1:0] v;
    v = DW'(r);
    if (v == '0) return DW'(1);
    if (v > DW'(mx)) return DW'(mx);
    return v;
  endfunction

  function automatic split_t split_pos(input logic [tfs_pkg::POS_W-1:0] pos,
                                       input logic [DW-1:0] size);
    split_t        s;
    logic [DW-1:0] ip;
    logic [DW-1:0] nx;
    ip = DW'(pos >> FB);
    if (ip >= size) begin
      s.lo   = size - DW'(1);
      s.frac = '1;
      s.sat  = 1'b1;
    end else begin
      s.lo   = ip;
      s.frac = pos[FB-1:0];
      s.sat  = 1'b0;
    end
    nx = s.lo + DW'(1);
    if (s.frac == '0) s.hi = s.lo;
    else if (nx >= size) s.hi = '0;
    else s.hi = nx;
    return s;
  endfunction

  // control
  logic                        busy;
  logic                        is_query;
  logic [tfs_pkg::STEP_W-1:0]  step;
  logic [tfs_pkg::CNT_W-1:0]   pending;
  logic [tfs_pkg::CNT_W-1:0]   pending_next;

  // payload of the word in hand
  logic                           wok;
  logic [tfs_pkg::ADDR_W-1:0]     waddr;
  logic signed [tfs_pkg::SAMPLE_W-1:0] wdata;
  logic [tfs_pkg::FRAME_W-1:0]    t_lo, t_hi;
  logic [tfs_pkg::ROW_W-1:0]      r_lo, r_hi;
  logic [tfs_pkg::COL_W-1:0]      c_lo, c_hi;
  logic [tfs_pkg::WGT_W-1:0]      wt_lo, wt_hi, wy_lo, wy_hi, wx_lo, wx_hi;
  logic                           qflag;

  // decode
  logic [DW-1:0]               h_eff, w_eff;
  split_t                      rs, cs;
  logic [tfs_pkg::TIME_W-1:0]  t_sat;
  logic                        t_over;
  logic [tfs_pkg::FRAME_W-1:0] t0;
  logic [FB-1:0]               tf;
  logic                        accept;
  logic                        last_issue;
  logic                        wr_ok;

  always_comb begin
    h_eff  = eff_size(active_height, tfs_pkg::MAX_ROWS);
    w_eff  = eff_size(active_width, tfs_pkg::MAX_COLS);
    rs     = split_pos(query_row, h_eff);
    cs     = split_pos(query_col, w_eff);
    t_over = query_time > T_MAX;
    t_sat  = t_over ? T_MAX : query_time;
    t0     = tfs_pkg::FRAME_W'(t_sat >> FB);
    tf     = t_sat[FB-1:0];
    wr_ok  = (int'(frame_slot) < tfs_pkg::FRAME_COUNT) &&
             (int'(write_row) < tfs_pkg::MAX_ROWS) &&
             (int'(write_col) < tfs_pkg::MAX_COLS);
  end

  assign last_issue = busy && (!is_query || step == LAST_STEP);
  assign in_ready   = (!busy || last_issue) && (pending != tfs_pkg::CNT_W'(tfs_pkg::QDEPTH));
  assign accept     = in_valid && in_ready;

  always_comb begin
    pending_next = pending;
    if (accept && kind == tfs_pkg::KIND_QUERY) pending_next = pending_next + tfs_pkg::CNT_W'(1);
    if (pop) pending_next = pending_next - tfs_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      step    <= '0;
      pending <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        step <= '0;
      end else if (last_issue) begin
        busy <= 1'b0;
      end else if (busy) begin
        step <= step + tfs_pkg::STEP_W'(1);
      end
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      is_query <= (kind == tfs_pkg::KIND_QUERY);
      wok      <= wr_ok;
      waddr    <= {tfs_pkg::FRAME_W'(frame_slot), tfs_pkg::ROW_W'(write_row),
                   tfs_pkg::COL_W'(write_col)};
      wdata    <= write_value;
      t_lo     <= t0;
      t_hi     <= (tf != '0) ? t0 + tfs_pkg::FRAME_W'(1) : t0;
      r_lo     <= tfs_pkg::ROW_W'(rs.lo);
      r_hi     <= tfs_pkg::ROW_W'(rs.hi);
      c_lo     <= tfs_pkg::COL_W'(cs.lo);
      c_hi     <= tfs_pkg::COL_W'(cs.hi);
      wt_lo    <= ONE - tfs_pkg::WGT_W'(tf);
      wt_hi    <= tfs_pkg::WGT_W'(tf);
      wy_lo    <= ONE - tfs_pkg::WGT_W'(rs.frac);
      wy_hi    <= tfs_pkg::WGT_W'(rs.frac);
      wx_lo    <= ONE - tfs_pkg::WGT_W'(cs.frac);
      wx_hi    <= tfs_pkg::WGT_W'(cs.frac);
      qflag    <= t_over || rs.sat || cs.sat;
    end
  end

  // step bits walk frame, row, column corners in that order
  always_comb begin
    mem.en    = busy && (is_query || wok);
    mem.we    = !is_query;
    mem.addr  = is_query ? {step[2] ? t_hi : t_lo, step[1] ? r_hi : r_lo,
                            step[0] ? c_hi : c_lo} : waddr;
    mem.wdata = wdata;
    tap.valid = busy && is_query;
    tap.first = (step == '0);
    tap.last  = (step == LAST_STEP);
    tap.flag  = qflag;
    tap.wt    = step[2] ? wt_hi : wt_lo;
    tap.wy    = step[1] ? wy_hi : wy_lo;
    tap.wx    = step[0] ? wx_hi : wx_lo;
  end

`include "trilinear_frame_sampler_top_macros.svh"

  `TFS_ASSERT_NEXT(a_step_advance, busy && is_query && step != LAST_STEP, busy && step == $past(step) + tfs_pkg::STEP_W'(1), "query taps did not advance")
  `TFS_ASSERT_NEXT(a_new_after_last, tap.valid && tap.last, !tap.valid || tap.first, "tap after last is not a first")

endmodule

`default_nettype wire

// File: rtl/tfs_mac.sv
// Weight product, sample multiply and accumulate over the eight taps.
// Depends on tfs_pkg; takes taps from tfs_seq and read data from tfs_store.
`default_nettype none

module tfs_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire tfs_pkg::tap_t                       tap,
  input  wire logic signed [tfs_pkg::SAMPLE_W-1:0] rdata,
  output tfs_pkg::res_t                            res
);

  localparam int SHIFT = 3 * tfs_pkg::FRAC_BITS;
  localparam logic signed [tfs_pkg::ACC_W-1:0] BIAS = tfs_pkg::ACC_W'((1 << SHIFT) - 1);
  localparam logic signed [tfs_pkg::ACC_W-1:0] ZERO = '0;
  localparam logic signed [tfs_pkg::ACC_W-1:0] S_MAX = tfs_pkg::ACC_W'(32767);
  localparam logic signed [tfs_pkg::ACC_W-1:0] S_MIN = -tfs_pkg::ACC_W'(32768);

  logic                          v1, first1, last1, flag1;
  logic [tfs_pkg::WTY_W-1:0]     wty1;
  logic [tfs_pkg::WGT_W-1:0]     wx1;
  logic                          v2, first2, last2, flag2;
  logic [tfs_pkg::WGT3_W-1:0]    w2;
  logic signed [tfs_pkg::SAMPLE_W-1:0] s2;
  logic                          v3, first3, last3, flag3;
  logic signed [tfs_pkg::PROD_W-1:0] p3;
  logic                          done, flag4;
  logic signed [tfs_pkg::ACC_W-1:0] acc;

  logic [2*tfs_pkg::WGT_W-1:0]             wty_full;
  logic [tfs_pkg::WTY_W+tfs_pkg::WGT_W-1:0] w_full;
  logic signed [tfs_pkg::ACC_W-1:0]        q;

  assign wty_full = tap.wt * tap.wy;
  assign w_full   = wty1 * wx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= tap.valid;
      v2   <= v1;
      v3   <= v2;
      done <= v3 && last3;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= tap.first;
    last1  <= tap.last;
    flag1  <= tap.flag;
    wty1   <= wty_full[tfs_pkg::WTY_W-1:0];
    wx1    <= tap.wx;
    first2 <= first1;
    last2  <= last1;
    flag2  <= flag1;
    w2     <= w_full[tfs_pkg::WGT3_W-1:0];
    s2     <= rdata;
    first3 <= first2;
    last3  <= last2;
    flag3  <= flag2;
    p3     <= s2 * $signed({1'b0, w2});
    if (v3) begin
      acc   <= first3 ? p3 : acc + p3;
      flag4 <= flag3;
    end
  end

  // truncate toward zero: bias negatives before the arithmetic shift
  always_comb begin
    q = (acc + (acc[tfs_pkg::ACC_W-1] ? BIAS : ZERO)) >>> SHIFT;
    res.valid = done;
    res.flag  = flag4;
    if (q > S_MAX) res.sample = tfs_pkg::SAMPLE_W'(S_MAX);
    else if (q < S_MIN) res.sample = tfs_pkg::SAMPLE_W'(S_MIN);
    else res.sample = q[tfs_pkg::SAMPLE_W-1:0];
  end

`include "trilinear_frame_sampler_top_macros.svh"

  `TFS_ASSERT_NOW(a_last_tap_done, tap.valid && tap.last, ##4 res.valid, "blend not finished four cycles after last tap")
  `TFS_ASSERT_NEXT(a_done_single, res.valid, !res.valid, "two results in consecutive cycles")

endmodule

`default_nettype wire

// File: rtl/tfs_outbuf.sv
// Two-word result queue that parts the blend pipeline from the consumer.
// Depends on tfs_pkg for the result struct and queue depth.
`default_nettype none

module tfs_outbuf (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tfs_pkg::res_t                 push,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [tfs_pkg::SAMPLE_W-1:0] sample_out,
  output logic                               range_flag,
  output logic                               pop
);

  localparam int PTR_W = $clog2(tfs_pkg::QDEPTH);

  logic signed [tfs_pkg::SAMPLE_W-1:0] sample_q [tfs_pkg::QDEPTH];
  logic                                flag_q   [tfs_pkg::QDEPTH];
  logic [PTR_W-1:0]                    wp, rp;
  logic [tfs_pkg::CNT_W-1:0]           count;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign sample_out = sample_q[rp];
  assign range_flag = flag_q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push.valid) wp <= wp + PTR_W'(1);
      if (pop) rp <= rp + PTR_W'(1);
      if (push.valid && !pop) count <= count + tfs_pkg::CNT_W'(1);
      else if (pop && !push.valid) count <= count - tfs_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      sample_q[wp] <= push.sample;
      flag_q[wp]   <= push.flag;
    end
  end

`include "trilinear_frame_sampler_top_macros.svh"

  `TFS_ASSERT_NOW(a_no_overflow, push.valid && !pop, count != tfs_pkg::CNT_W'(tfs_pkg::QDEPTH), "result queue overflow")

endmodule

`default_nettype wire

// File: rtl/trilinear_frame_sampler_top.sv
// Trilinear frame sampler: a query reads eight samples, one a cycle, from the
// single-port frame store and holds off new input until its last read is issued;
// writes go one per cycle while the input is not stalled.
// Input, writes included, stalls while two query results are in flight or queued.
// Reset (rst, synchronous): clears control and sets both active sizes to 128;
// the frame store is not cleared and holds no data until written.
`default_nettype none

module trilinear_frame_sampler_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                kind,
  input  wire logic [tfs_pkg::SLOT_W-1:0]          frame_slot,
  input  wire logic [tfs_pkg::WROW_W-1:0]          write_row,
  input  wire logic [tfs_pkg::WCOL_W-1:0]          write_col,
  input  wire logic signed [tfs_pkg::SAMPLE_W-1:0] write_value,
  input  wire logic [tfs_pkg::TIME_W-1:0]          query_time,
  input  wire logic [tfs_pkg::POS_W-1:0]           query_row,
  input  wire logic [tfs_pkg::POS_W-1:0]           query_col,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [tfs_pkg::SAMPLE_W-1:0]      sample_out,
  output logic                                     range_flag,
  input  wire logic                                cfg_write,
  input  wire logic [tfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tfs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [tfs_pkg::CFG_DATA_W-1:0]      active_width;
  logic [tfs_pkg::CFG_DATA_W-1:0]      active_height;
  tfs_pkg::mem_req_t                   mem;
  tfs_pkg::tap_t                       tap;
  tfs_pkg::res_t                       res;
  logic signed [tfs_pkg::SAMPLE_W-1:0] rdata;
  logic                                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= tfs_pkg::SIZE_RESET;
      active_height <= tfs_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        tfs_pkg::REG_ACTIVE_WIDTH:  active_width  <= cfg_data;
        tfs_pkg::REG_ACTIVE_HEIGHT: active_height <= cfg_data;
        default: ;
      endcase
    end
  end

  tfs_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .frame_slot    (frame_slot),
    .write_row     (write_row),
    .write_col     (write_col),
    .write_value   (write_value),
    .query_time    (query_time),
    .query_row     (query_row),
    .query_col     (query_col),
    .active_width  (active_width),
    .active_height (active_height),
    .pop           (pop),
    .mem           (mem),
    .tap           (tap)
  );

  tfs_store u_store (
    .clk   (clk),
    .req   (mem),
    .rdata (rdata)
  );

  tfs_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .tap   (tap),
    .rdata (rdata),
    .res   (res)
  );

  tfs_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .range_flag (range_flag),
    .pop        (pop)
  );

endmodule

`default_nettype wire
